@@ rtl/wnsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnsr_pkg
// Shared constants and types for the wheel no-slip residual block.
// ----------------------------------------------------------------------------
package wnsr_pkg;

  localparam int CordicStages = 16;
  localparam int MaxStages = 24;
  localparam int AngW      = 32;
  localparam int CordW     = 40;

  localparam logic signed [CordW-1:0] CordX0 = 40'sd652032874;

  localparam logic [15:0] RstRadius = 16'd3630;
  localparam logic [15:0] RstHalfL  = 16'd8520;
  localparam logic [15:0] RstHalfW  = 16'd8684;
  localparam logic [15:0] RstCaster = 16'd328;
  localparam logic [15:0] RstHeight = 16'd1122;

  localparam logic [2:0] RegRadius = 3'd0;
  localparam logic [2:0] RegHalfL  = 3'd1;
  localparam logic [2:0] RegHalfW  = 3'd2;
  localparam logic [2:0] RegCaster = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;

  // Payload carried alongside the trig pipeline.
  typedef struct packed {
    logic [1:0]         wheel_index;
    logic signed [23:0] base_vx;
    logic signed [23:0] base_vy;
    logic signed [23:0] yaw_rate;
    logic signed [24:0] sw_rate;
    logic signed [23:0] roll_rate;
  } side_t;

  // Arctangent table in units of 2^-32 turn.
  function automatic logic [AngW-1:0] atan_turn(input int i);
    logic [AngW-1:0] r;
    unique case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wnsr_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnsr_cordic_cell
// One registered CORDIC rotation stage for two angles in parallel.
// ----------------------------------------------------------------------------
module wnsr_cordic_cell #(
  parameter int Shift = 0
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [wnsr_pkg::CordW-1:0] xa_in,
  input  wire logic signed [wnsr_pkg::CordW-1:0] ya_in,
  input  wire logic        [wnsr_pkg::AngW-1:0]  pa_in,
  input  wire logic signed [wnsr_pkg::CordW-1:0] xb_in,
  input  wire logic signed [wnsr_pkg::CordW-1:0] yb_in,
  input  wire logic        [wnsr_pkg::AngW-1:0]  pb_in,
  output logic signed      [wnsr_pkg::CordW-1:0] xa,
  output logic signed      [wnsr_pkg::CordW-1:0] ya,
  output logic             [wnsr_pkg::AngW-1:0]  pa,
  output logic signed      [wnsr_pkg::CordW-1:0] xb,
  output logic signed      [wnsr_pkg::CordW-1:0] yb,
  output logic             [wnsr_pkg::AngW-1:0]  pb
);
  import wnsr_pkg::*;

  localparam logic [AngW-1:0] Atan = atan_turn(Shift);

  logic signed [CordW-1:0] dxa, dya, dxb, dyb;

  assign dxa = ya_in >>> Shift;
  assign dya = xa_in >>> Shift;
  assign dxb = yb_in >>> Shift;
  assign dyb = xb_in >>> Shift;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pa_in[AngW-1]) begin
        xa <= xa_in - dxa; ya <= ya_in + dya; pa <= pa_in - Atan;
      end else begin
        xa <= xa_in + dxa; ya <= ya_in - dya; pa <= pa_in + Atan;
      end
      if (!pb_in[AngW-1]) begin
        xb <= xb_in - dxb; yb <= yb_in + dyb; pb <= pb_in - Atan;
      end else begin
        xb <= xb_in + dxb; yb <= yb_in - dyb; pb <= pb_in + Atan;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/wnsr_combine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnsr_combine
// Products of lengths, rates and trig values, summed, rounded, saturated.
// ----------------------------------------------------------------------------
module wnsr_combine (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire wnsr_pkg::side_t     side,
  input  wire logic signed [17:0]  ct,
  input  wire logic signed [17:0]  st,
  input  wire logic signed [17:0]  cp,
  input  wire logic signed [17:0]  sp,
  input  wire logic [15:0]         rad,
  input  wire logic [15:0]         hl,
  input  wire logic [15:0]         hw,
  input  wire logic [15:0]         cst,
  input  wire logic [15:0]         hgt,
  output logic signed [31:0]       rx,
  output logic signed [31:0]       ry,
  output logic                     sat
);
  import wnsr_pkg::*;

  // Stage 1: length * rate (signed, sign pattern applied)
  logic signed [41:0] lw, dw, ar, wxs, wzs;
  logic signed [17:0] ct1, st1, cp1, sp1;
  logic signed [23:0] vx1, vy1;
  logic signed [41:0] lw_p, dw_p, wxs_p, wzs_p;

  assign lw_p  = $signed({1'b0, hl})  * side.yaw_rate;
  assign dw_p  = $signed({1'b0, hw})  * side.yaw_rate;
  assign wxs_p = $signed({1'b0, cst}) * side.sw_rate;
  assign wzs_p = $signed({1'b0, hgt}) * side.sw_rate;

  always_ff @(posedge clk) begin
    if (en) begin
      lw  <= side.wheel_index[1] ? -lw_p : lw_p;
      wzs <= side.wheel_index[1] ? -wzs_p : wzs_p;
      dw  <= side.wheel_index[0] ? -dw_p : dw_p;
      wxs <= side.wheel_index[0] ? -wxs_p : wxs_p;
      ar  <= 42'($signed({1'b0, rad}) * side.roll_rate);
      ct1 <= ct; st1 <= st; cp1 <= cp; sp1 <= sp;
      vx1 <= side.base_vx; vy1 <= side.base_vy;
    end
  end

  // Stage 2: products with trig (each 42 x 18)
  logic signed [59:0] p_lct, p_dst, p_asp, p_xsp, p_zcp;
  logic signed [59:0] p_lst, p_dct, p_acp, p_xcp, p_zsp;
  logic signed [23:0] vx2, vy2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lct <= lw * ct1;  p_dst <= dw * st1;  p_asp <= ar * sp1;
      p_xsp <= wxs * sp1; p_zcp <= wzs * cp1;
      p_lst <= lw * st1;  p_dct <= dw * ct1;  p_acp <= ar * cp1;
      p_xcp <= wxs * cp1; p_zsp <= wzs * sp1;
      vx2 <= vx1; vy2 <= vy1;
    end
  end

  // Stage 3: sums in Q.32 (velocity LSB scaled by 2^32)
  logic signed [63:0] accx, accy;

  always_ff @(posedge clk) begin
    if (en) begin
      accx <= {8'(vx2 >>> 23), vx2, 32'd0} + 64'(p_lct) - 64'(p_dst)
              - 64'(p_asp) - 64'(p_xsp) + 64'(p_zcp);
      accy <= {8'(vy2 >>> 23), vy2, 32'd0} + 64'(p_lst) + 64'(p_dct)
              + 64'(p_acp) + 64'(p_xcp) + 64'(p_zsp);
    end
  end

  // Stage 4: round half up, saturate
  logic signed [63:0] rnx, rny;
  logic signed [31:0] qx, qy;
  logic               ox, oy;

  assign rnx = (accx + 64'sd2147483648) >>> 32;
  assign rny = (accy + 64'sd2147483648) >>> 32;
  assign ox  = (rnx[63:31] != {33{rnx[63]}});
  assign oy  = (rny[63:31] != {33{rny[63]}});
  assign qx  = ox ? (rnx[63] ? 32'sh80000000 : 32'sh7fffffff) : rnx[31:0];
  assign qy  = oy ? (rny[63] ? 32'sh80000000 : 32'sh7fffffff) : rny[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rx  <= qx;
      ry  <= qy;
      sat <= ox | oy;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wheel_no_slip_residual.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_no_slip_residual
// No-slip velocity residuals of one steered wheel of a four-wheel base.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  in      | valid ready + eight item fields          | one wheel per beat
//  out     | out_valid out_ready residual_x/_y sat.   | one result per beat
//  cfg     | psel penable pwrite paddr pwdata prdata  | geometry lengths
//
// One beat per cycle while not stalled. The path is an entry cell, a
// chain of CORDIC cells (one per stage), a trig rounding cell, and four
// product/sum cells. The whole chain advances only when the output register
// is empty or being taken, so a stall holds every cell. Reset clears the
// valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module wheel_no_slip_residual #(
  parameter int CORDIC_STAGES = wnsr_pkg::CordicStages
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    ready,
  input  wire logic [1:0]         wheel_index,
  input  wire logic signed [15:0] heading,
  input  wire logic signed [15:0] steer_angle,
  input  wire logic signed [23:0] base_vx,
  input  wire logic signed [23:0] base_vy,
  input  wire logic signed [23:0] yaw_rate,
  input  wire logic signed [23:0] steer_rate,
  input  wire logic signed [23:0] roll_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      residual_x,
  output logic signed [31:0]      residual_y,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import wnsr_pkg::*;

  localparam int NSt   = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
  localparam int Depth = NSt + 6;

  // Registers
  logic [15:0] rad, hl, hw, cst, hgt;
  logic [2:0]  ridx;
  logic        wr;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad <= RstRadius; hl <= RstHalfL; hw <= RstHalfW;
      cst <= RstCaster; hgt <= RstHeight;
    end else if (wr) begin
      unique case (ridx)
        RegRadius: rad <= pwdata[15:0];
        RegHalfL:  hl  <= pwdata[15:0];
        RegHalfW:  hw  <= pwdata[15:0];
        RegCaster: cst <= pwdata[15:0];
        RegHeight: hgt <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegRadius: prdata = {16'd0, rad};
      RegHalfL:  prdata = {16'd0, hl};
      RegHalfW:  prdata = {16'd0, hw};
      RegCaster: prdata = {16'd0, cst};
      RegHeight: prdata = {16'd0, hgt};
      default:   prdata = '0;
    endcase
  end

  // Chain control: everything advances together
  logic             en;
  logic [Depth-1:0] vld;

  assign en    = !out_valid || out_ready;
  assign ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], valid};
  end
  assign out_valid = vld[Depth-1];

  // Entry cell: fold angles into the right half plane
  logic [AngW-1:0] pth0, pph0;
  logic [15:0]     phi;
  logic [NSt:0]    fa, fb;
  side_t           sd [NSt+2];
  side_t           sd_in;

  assign phi = heading + steer_angle;

  always_comb begin
    sd_in.wheel_index = wheel_index;
    sd_in.base_vx     = base_vx;
    sd_in.base_vy     = base_vy;
    sd_in.yaw_rate    = yaw_rate;
    sd_in.sw_rate     = 25'(steer_rate) + 25'(yaw_rate);
    sd_in.roll_rate   = roll_rate;
  end

  // Adding a half turn in the folded quadrants leaves bit 15 equal to bit 14.
  always_ff @(posedge clk) begin
    if (en) begin
      pth0  <= {heading[14], heading[14:0], 16'd0};
      pph0  <= {phi[14], phi[14:0], 16'd0};
      fa[0] <= heading[15] ^ heading[14];
      fb[0] <= phi[15] ^ phi[14];
      sd[0] <= sd_in;
    end
  end

  // CORDIC chain
  logic signed [CordW-1:0] xa [NSt+1];
  logic signed [CordW-1:0] ya [NSt+1];
  logic        [AngW-1:0]  pa [NSt+1];
  logic signed [CordW-1:0] xb [NSt+1];
  logic signed [CordW-1:0] yb [NSt+1];
  logic        [AngW-1:0]  pb [NSt+1];

  assign xa[0] = CordX0; assign ya[0] = '0; assign pa[0] = pth0;
  assign xb[0] = CordX0; assign yb[0] = '0; assign pb[0] = pph0;

  for (genvar g = 0; g < NSt; g++) begin : g_cell
    wnsr_cordic_cell #(.Shift(g)) u_cell (
      .clk(clk), .en(en),
      .xa_in(xa[g]), .ya_in(ya[g]), .pa_in(pa[g]),
      .xb_in(xb[g]), .yb_in(yb[g]), .pb_in(pb[g]),
      .xa(xa[g+1]), .ya(ya[g+1]), .pa(pa[g+1]),
      .xb(xb[g+1]), .yb(yb[g+1]), .pb(pb[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        fa[g+1] <= fa[g];
        fb[g+1] <= fb[g];
        sd[g+1] <= sd[g];
      end
    end
  end

  // Trig rounding cell: Q2.30 to Q1.16, half up, undo the fold
  logic signed [CordW-1:0] rca, rsa, rcb, rsb;
  logic signed [17:0]      ct, st, cp, sp;

  assign rca = (xa[NSt] + 40'sd8192) >>> 14;
  assign rsa = (ya[NSt] + 40'sd8192) >>> 14;
  assign rcb = (xb[NSt] + 40'sd8192) >>> 14;
  assign rsb = (yb[NSt] + 40'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      ct <= fa[NSt] ? -rca[17:0] : rca[17:0];
      st <= fa[NSt] ? -rsa[17:0] : rsa[17:0];
      cp <= fb[NSt] ? -rcb[17:0] : rcb[17:0];
      sp <= fb[NSt] ? -rsb[17:0] : rsb[17:0];
      sd[NSt+1] <= sd[NSt];
    end
  end

  wnsr_combine u_comb (
    .clk(clk), .en(en), .side(sd[NSt+1]),
    .ct(ct), .st(st), .cp(cp), .sp(sp),
    .rad(rad), .hl(hl), .hw(hw), .cst(cst), .hgt(hgt),
    .rx(residual_x), .ry(residual_y), .sat(saturated)
  );

  // Assertions
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(residual_x))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    ready == (!out_valid || out_ready))
    else $error("ready does not follow output slot");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule
`default_nettype wire
